@@ rtl/lz78_pkg.sv @@
// ============================================================================
// lz78 encoder package
// shared widths, codes and payload types of the lz78 stream encoder
// ============================================================================
`default_nettype none

package lz78_pkg;

    // dictionary size, root phrase included
    localparam int DICT_ENTRIES = 1024;

    localparam int SYM_W    = 8;
    localparam int CODE_W   = 11;
    localparam int PHRASE_W = $clog2(DICT_ENTRIES);
    localparam int NEXT_W   = $clog2(DICT_ENTRIES + 1);
    localparam int ADDR_W   = PHRASE_W + SYM_W;

    // child table depth, rounded up to a full address space
    localparam int TABLE_DEPTH = 1 << ADDR_W;

    // stream tag kept with every table entry
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    typedef enum logic [1:0] {
        KIND_PAIR  = 2'd0,
        KIND_FINAL = 2'd1,
        KIND_COUNT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_CLEAR,
        PH_ISSUE,
        PH_RESOLVE,
        PH_FINAL
    } phase_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } sym_t;

    typedef struct packed {
        kind_t             kind;
        logic [CODE_W-1:0] code;
        logic [SYM_W-1:0]  literal;
        logic              end_of_run;
    } res_t;

    typedef struct packed {
        logic [EPOCH_W-1:0]  epoch;
        logic [PHRASE_W-1:0] child;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/lz78_stream_encoder.sv @@
// ============================================================================
// lz78 stream encoder
// byte-wise lz78 phrase encoder built around one single-port child table
// ============================================================================
//
// usage
//   input channel sym_*: one byte per transfer, with a flag on the last byte
//   of a stream. output channel res_*: (code, byte) pairs, then on the last
//   byte an optional final code and the dictionary entry count, which carries
//   end_of_run.
//   each byte takes two steps: one to read the child table entry at
//   {phrase, byte}, one to resolve the hit or miss and write the new entry.
//   the read data picks the next read address, so reads cannot overlap.
//   a one-entry input buffer takes the next byte while the current one is
//   being resolved. the last byte of a stream adds a final step for the
//   count result.
//   a result reaches res_* through the table read and the output queue.
//   results sit in a two-entry output queue; while res_stall is high the
//   queue fills and then the encoder holds, and sym_stall rises.
//   every entry carries a stream tag, so ending a stream only bumps the tag.
//   after reset, and once every 255 streams when the tag wraps, the table is
//   swept to zero, all 262144 entries, one entry a cycle, with sym_stall high.
//
// ============================================================================
`default_nettype none

module lz78_stream_encoder
    import lz78_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic sym_valid,
    output logic      sym_stall,
    input  wire sym_t sym_data,

    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res_data
);

    // ------------------------------------------------------------------
    // input buffer
    // ------------------------------------------------------------------
    sym_t   buf_reg;
    logic   buf_valid_reg;
    logic   sym_xfer;
    logic   issue;

    phase_t state_reg, state_next;

    // busy during the clearing sweep or while a byte is waiting
    assign sym_stall = buf_valid_reg || (state_reg == PH_CLEAR);
    assign sym_xfer  = sym_valid && !sym_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
        end
        else if (sym_xfer)
        begin
            buf_valid_reg <= 1'b1;
        end
        else if (issue)
        begin
            buf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sym_xfer)
        begin
            buf_reg <= sym_data;
        end
    end

    // ------------------------------------------------------------------
    // output queue, two entries, one write per cycle
    // ------------------------------------------------------------------
    res_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    res_t       push_data;
    logic       pop;

    assign res_valid = (cnt_reg != 2'd0);
    assign res_data  = fifo_reg[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    // ------------------------------------------------------------------
    // child table: {epoch, child} at {phrase, byte}
    // ------------------------------------------------------------------
    entry_t              dict_mem [TABLE_DEPTH];
    entry_t              rd_data_reg;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_addr;
    entry_t              mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dict_mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= dict_mem[mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // encoder state
    // ------------------------------------------------------------------
    logic [PHRASE_W-1:0] cur_reg, cur_next;
    logic [NEXT_W-1:0]   next_code_reg, next_code_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic                last_reg;
    logic                hit;
    logic                has_room;

    // entries from earlier streams carry a stale tag and read as no child
    assign hit      = (rd_data_reg.epoch == epoch_reg);
    assign has_room = (next_code_reg < NEXT_W'(DICT_ENTRIES));

    // at most one result goes out in the resolve cycle, so one free slot suffices
    assign issue = (state_reg == PH_ISSUE) && buf_valid_reg && (cnt_reg != 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_CLEAR;
            cur_reg       <= '0;
            next_code_reg <= NEXT_W'(1);
            epoch_reg     <= EPOCH_FIRST;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            next_code_reg <= next_code_next;
            epoch_reg     <= epoch_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    // address and last flag of the byte under work
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            addr_reg <= {cur_reg, buf_reg.symbol};
            last_reg <= buf_reg.last;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        next_code_next = next_code_reg;
        epoch_next     = epoch_reg;
        clr_cnt_next   = clr_cnt_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = addr_reg;
        mem_wdata      = '0;
        push           = 1'b0;
        push_data      = '0;

        unique case (state_reg)
            PH_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = PH_ISSUE;
                end
            end

            PH_ISSUE:
            begin
                if (issue)
                begin
                    mem_re     = 1'b1;
                    mem_addr   = {cur_reg, buf_reg.symbol};
                    state_next = PH_RESOLVE;
                end
            end

            PH_RESOLVE:
            begin
                if (hit)
                begin
                    // byte extends the phrase
                    cur_next = rd_data_reg.child;
                    if (last_reg)
                    begin
                        push                 = 1'b1;
                        push_data.kind       = KIND_FINAL;
                        push_data.code       = CODE_W'(rd_data_reg.child);
                        push_data.literal    = '0;
                        push_data.end_of_run = 1'b0;
                    end
                end
                else
                begin
                    // new phrase, unless the dictionary is frozen
                    if (has_room)
                    begin
                        mem_we          = 1'b1;
                        mem_wdata.epoch = epoch_reg;
                        mem_wdata.child = next_code_reg[PHRASE_W-1:0];
                        next_code_next  = next_code_reg + NEXT_W'(1);
                    end
                    push                 = 1'b1;
                    push_data.kind       = KIND_PAIR;
                    push_data.code       = CODE_W'(addr_reg[ADDR_W-1:SYM_W]);
                    push_data.literal    = addr_reg[SYM_W-1:0];
                    push_data.end_of_run = 1'b0;
                    cur_next             = '0;
                end
                state_next = last_reg ? PH_FINAL : PH_ISSUE;
            end

            PH_FINAL:
            begin
                if (cnt_reg != 2'd2)
                begin
                    push                 = 1'b1;
                    push_data.kind       = KIND_COUNT;
                    push_data.code       = CODE_W'(next_code_reg);
                    push_data.literal    = '0;
                    push_data.end_of_run = 1'b1;
                    cur_next             = '0;
                    next_code_next       = NEXT_W'(1);
                    if (epoch_reg == EPOCH_LAST)
                    begin
                        // tag wraps: sweep the table before the next stream
                        epoch_next   = EPOCH_FIRST;
                        clr_cnt_next = '0;
                        state_next   = PH_CLEAR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + EPOCH_W'(1);
                        state_next = PH_ISSUE;
                    end
                end
            end

            default:
            begin
                state_next = PH_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_resolve_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_RESOLVE) |-> ($past(state_reg) == PH_ISSUE))
        else $error("resolve cycle without a table read");

    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != 2'd2))
        else $error("result written into a full output queue");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_code_reg != NEXT_W'(0)) && (next_code_reg <= NEXT_W'(DICT_ENTRIES)))
        else $error("entry count out of range");

    a_stream_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == PH_FINAL) && push) |=>
            ((cur_reg == '0) && (next_code_reg == NEXT_W'(1))))
        else $error("dictionary state not reset after stream end");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (!mem_we && (state_reg == PH_ISSUE) && !buf_valid_reg == 1'b0))
        else $error("table read without a waiting byte or with a write");

endmodule

`default_nettype wire
